/* rtl/core/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Result kind codes, control word carried along the cell chains, and the
// fixed widths of the result fields.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // width of the signed root fields and of the imaginary magnitude
    localparam int ROOT_W = 48;
    localparam int IMAG_W = 47;

    // kind of solution
    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_LINEAR   = 3'd1,
        KIND_TWO_REAL = 3'd2,
        KIND_DOUBLE   = 3'd3,
        KIND_COMPLEX  = 3'd4
    } t_kind;

    // control word that travels with every coefficient set
    typedef struct packed {
        logic  vld;
        t_kind kind;
    } t_ctl;

endpackage

/* rtl/core/qrs_front.sv */
// ----------------------------------------------------------------------------
// qrs_front: coefficient capture and discriminant
// Registers the coefficients, forms b*b and a*c, then the exact discriminant
// magnitude, the kind of solution, the scaled numerator and the divisor.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; #(
    parameter int W   = 16,
    parameter int F   = 16,
    parameter int DW  = 34,
    parameter int NW  = 34,
    parameter int DVW = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    input  logic signed [W-1:0]   i_c,
    output t_ctl                  o_ctl,
    output logic [DW-1:0]         o_dmag,
    output logic signed [NW-1:0]  o_nb,
    output logic [DVW-1:0]        o_den,
    output logic                  o_den_neg
);

    logic                  r1_vld;
    logic signed [W-1:0]   r1_a, r1_b, r1_c;
    logic                  r2_vld;
    logic signed [W-1:0]   r2_a, r2_b, r2_c;
    logic signed [2*W-1:0] r_bb, r_ac;

    logic signed [DW:0]    n_d;
    logic signed [DVW:0]   n_ax, n_amag, n_bx, n_bmag;
    t_ctl                  n_ctl;
    logic [DW-1:0]         n_dmag;
    logic signed [NW-1:0]  n_nb;
    logic [DVW-1:0]        n_den;
    logic                  n_den_neg;

    t_ctl                  r_ctl;
    logic [DW-1:0]         r_dmag;
    logic signed [NW-1:0]  r_nb;
    logic [DVW-1:0]        r_den;
    logic                  r_den_neg;

    // capture the word and form the products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_load;
            r2_vld <= r1_vld;
        end
        r1_a <= i_a;
        r1_b <= i_b;
        r1_c <= i_c;
        r2_a <= r1_a;
        r2_b <= r1_b;
        r2_c <= r1_c;
        r_bb <= r1_b * r1_b;
        r_ac <= r1_a * r1_c;
    end

    // discriminant, kind, numerator and divisor
    always_comb begin
        n_d     = (DW+1)'(r_bb) - ((DW+1)'(r_ac) <<< 2);
        n_dmag  = n_d[DW] ? DW'(-n_d) : DW'(n_d);
        n_ax    = (DVW+1)'(r2_a);
        n_amag  = n_ax[DVW] ? -n_ax : n_ax;
        n_bx    = (DVW+1)'(r2_b);
        n_bmag  = n_bx[DVW] ? -n_bx : n_bx;
        n_ctl.vld = r2_vld;
        if (r2_a == '0) begin
            n_ctl.kind = (r2_b != '0) ? KIND_LINEAR : KIND_NONE;
            n_nb       = -(NW'(r2_c) <<< F);
            n_den      = DVW'(n_bmag);
            n_den_neg  = r2_b[W-1];
        end else begin
            if (n_d[DW])
                n_ctl.kind = KIND_COMPLEX;
            else if (n_d == '0)
                n_ctl.kind = KIND_DOUBLE;
            else
                n_ctl.kind = KIND_TWO_REAL;
            n_nb       = -(NW'(r2_b) <<< F);
            n_den      = DVW'(n_amag <<< 1);
            n_den_neg  = r2_a[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ctl.vld <= 1'b0;
        else
            r_ctl.vld <= n_ctl.vld;
        r_ctl.kind <= n_ctl.kind;
        r_dmag     <= n_dmag;
        r_nb       <= n_nb;
        r_den      <= n_den;
        r_den_neg  <= n_den_neg;
    end

    assign o_ctl     = r_ctl;
    assign o_dmag    = r_dmag;
    assign o_nb      = r_nb;
    assign o_den     = r_den;
    assign o_den_neg = r_den_neg;

endmodule

/* rtl/core/qrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the square root chain
// Brings down the next bit pair of the radicand, tries 4*root+1 against the
// partial remainder and shifts one root bit in.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell import qrs_pkg::*; #(
    parameter int SW  = 33,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [2*SW-1:0]   i_rad,
    input  logic [SW+1:0]     i_rem,
    input  logic [SW-1:0]     i_root,
    input  logic [SBW-1:0]    i_side,
    output t_ctl              o_ctl,
    output logic [2*SW-1:0]   o_rad,
    output logic [SW+1:0]     o_rem,
    output logic [SW-1:0]     o_root,
    output logic [SBW-1:0]    o_side
);

    logic [SW+3:0]   n_try, n_trial, n_diff;
    logic            n_fit;
    t_ctl            r_ctl;
    logic [2*SW-1:0] r_rad;
    logic [SW+1:0]   r_rem;
    logic [SW-1:0]   r_root;
    logic [SBW-1:0]  r_side;

    // trial subtract of 4*root+1
    always_comb begin
        n_try   = {i_rem, i_rad[2*SW-1 -: 2]};
        n_trial = {2'b00, i_root, 2'b01};
        n_diff  = n_try - n_trial;
        n_fit   = (n_try >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ctl.vld <= 1'b0;
        else
            r_ctl.vld <= i_ctl.vld;
        r_ctl.kind <= i_ctl.kind;
        r_rad      <= {i_rad[2*SW-3:0], 2'b00};
        r_rem      <= n_fit ? n_diff[SW+1:0] : n_try[SW+1:0];
        r_root     <= {i_root[SW-2:0], n_fit};
        r_side     <= i_side;
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

/* rtl/core/qrs_setup.sv */
// ----------------------------------------------------------------------------
// qrs_setup: numerators for the divider chain
// Forms two numerators from the scaled -b (-c if a is zero) and the root,
// splits them into magnitude and quotient sign for the unsigned dividers.
// ----------------------------------------------------------------------------
module qrs_setup import qrs_pkg::*; #(
    parameter int SW  = 33,
    parameter int NW  = 34,
    parameter int DVW = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [SW-1:0]         i_root,
    input  logic signed [NW-1:0]  i_nb,
    input  logic [DVW-1:0]        i_den,
    input  logic                  i_den_neg,
    output t_ctl                  o_ctl,
    output logic [1:0][NW-1:0]    o_num,
    output logic [1:0]            o_neg,
    output logic [DVW-1:0]        o_den
);

    logic signed [NW:0]  n_nbx, n_sx, n_n1, n_n2, n_m1, n_m2;
    logic [1:0]          n_neg;
    t_ctl                r_ctl;
    logic [1:0][NW-1:0]  r_num;
    logic [1:0]          r_neg;
    logic [DVW-1:0]      r_den;

    // pick numerators by kind
    always_comb begin
        n_nbx = (NW+1)'(i_nb);
        n_sx  = (NW+1)'({1'b0, i_root});
        case (i_ctl.kind)
            KIND_TWO_REAL: begin
                n_n1 = n_nbx + n_sx;
                n_n2 = n_nbx - n_sx;
            end
            KIND_COMPLEX: begin
                n_n1 = n_nbx;
                n_n2 = n_sx;
            end
            default: begin
                n_n1 = n_nbx;
                n_n2 = '0;
            end
        endcase
        n_m1     = n_n1[NW] ? -n_n1 : n_n1;
        n_m2     = n_n2[NW] ? -n_n2 : n_n2;
        n_neg[0] = n_n1[NW] ^ i_den_neg;
        n_neg[1] = (i_ctl.kind == KIND_COMPLEX) ? 1'b0 : (n_n2[NW] ^ i_den_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ctl.vld <= 1'b0;
        else
            r_ctl.vld <= i_ctl.vld;
        r_ctl.kind <= i_ctl.kind;
        r_num[0]   <= n_m1[NW-1:0];
        r_num[1]   <= n_m2[NW-1:0];
        r_neg      <= n_neg;
        r_den      <= i_den;
    end

    assign o_ctl = r_ctl;
    assign o_num = r_num;
    assign o_neg = r_neg;
    assign o_den = r_den;

endmodule

/* rtl/core/qrs_div_cell.sv */
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of the two-lane restoring divider
// Both lanes share the divisor; the numerator shifts out at the top while the
// quotient bits shift in at the bottom of the same register.
// ----------------------------------------------------------------------------
module qrs_div_cell import qrs_pkg::*; #(
    parameter int NW  = 34,
    parameter int DVW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    input  logic [DVW-1:0]       i_den,
    input  logic [1:0][DVW-1:0]  i_rem,
    input  logic [1:0][NW-1:0]   i_nq,
    input  logic [1:0]           i_neg,
    output t_ctl                 o_ctl,
    output logic [DVW-1:0]       o_den,
    output logic [1:0][DVW-1:0]  o_rem,
    output logic [1:0][NW-1:0]   o_nq,
    output logic [1:0]           o_neg
);

    logic [1:0][DVW:0]   n_try, n_diff;
    logic [1:0]          n_fit;
    logic [1:0][DVW-1:0] n_rem;
    logic [1:0][NW-1:0]  n_nq;
    t_ctl                r_ctl;
    logic [DVW-1:0]      r_den;
    logic [1:0][DVW-1:0] r_rem;
    logic [1:0][NW-1:0]  r_nq;
    logic [1:0]          r_neg;

    // bring down one bit and try the divisor in each lane
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_try[l]  = {i_rem[l], i_nq[l][NW-1]};
            n_diff[l] = n_try[l] - {1'b0, i_den};
            n_fit[l]  = (n_try[l] >= {1'b0, i_den});
            n_rem[l]  = n_fit[l] ? n_diff[l][DVW-1:0] : n_try[l][DVW-1:0];
            n_nq[l]   = {i_nq[l][NW-2:0], n_fit[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ctl.vld <= 1'b0;
        else
            r_ctl.vld <= i_ctl.vld;
        r_ctl.kind <= i_ctl.kind;
        r_den      <= i_den;
        r_rem      <= n_rem;
        r_nq       <= n_nq;
        r_neg      <= i_neg;
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_neg = r_neg;

endmodule

/* rtl/core/qrs_finish.sv */
// ----------------------------------------------------------------------------
// qrs_finish: result formatting
// Applies the quotient signs, saturates to the field ranges and routes the
// quotients to the result fields by kind; unused fields read zero.
// ----------------------------------------------------------------------------
module qrs_finish import qrs_pkg::*; #(
    parameter int NW = 34
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic [1:0][NW-1:0]        i_quo,
    input  logic [1:0]                i_neg,
    output logic                      o_valid,
    output logic [2:0]                o_kind,
    output logic signed [ROOT_W-1:0]  o_root_plus,
    output logic signed [ROOT_W-1:0]  o_root_minus,
    output logic signed [ROOT_W-1:0]  o_real_part,
    output logic [IMAG_W-1:0]         o_imag_part
);

    localparam int XW = (NW + 1 > ROOT_W + 1) ? NW + 1 : ROOT_W + 1;
    localparam int UW = (NW > IMAG_W + 1) ? NW : IMAG_W + 1;

    logic signed [XW-1:0]     n_x [2];
    logic [ROOT_W-1:0]        n_sat [2];
    logic [UW-1:0]            n_u;
    logic [IMAG_W-1:0]        n_im;
    logic signed [ROOT_W-1:0] n_rp, n_rm, n_re;
    logic [IMAG_W-1:0]        n_ip;

    logic                     r_valid;
    t_kind                    r_kind;
    logic signed [ROOT_W-1:0] r_rp, r_rm, r_re;
    logic [IMAG_W-1:0]        r_ip;

    // sign and saturate each lane
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_x[l] = i_neg[l] ? -XW'({1'b0, i_quo[l]}) : XW'({1'b0, i_quo[l]});
            if ((&n_x[l][XW-1:ROOT_W-1]) || !(|n_x[l][XW-1:ROOT_W-1]))
                n_sat[l] = n_x[l][ROOT_W-1:0];
            else
                n_sat[l] = n_x[l][XW-1] ? {1'b1, {(ROOT_W-1){1'b0}}}
                                        : {1'b0, {(ROOT_W-1){1'b1}}};
        end
        n_u  = UW'(i_quo[1]);
        n_im = (|n_u[UW-1:IMAG_W]) ? {IMAG_W{1'b1}} : n_u[IMAG_W-1:0];
    end

    // route by kind
    always_comb begin
        n_rp = '0;
        n_rm = '0;
        n_re = '0;
        n_ip = '0;
        case (i_ctl.kind)
            KIND_LINEAR, KIND_DOUBLE: begin
                n_rp = n_sat[0];
            end
            KIND_TWO_REAL: begin
                n_rp = n_sat[0];
                n_rm = n_sat[1];
            end
            KIND_COMPLEX: begin
                n_re = n_sat[0];
                n_ip = n_im;
            end
            default: begin
                n_rp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else
            r_valid <= i_ctl.vld;
        r_kind <= i_ctl.kind;
        r_rp   <= n_rp;
        r_rm   <= n_rm;
        r_re   <= n_re;
        r_ip   <= n_ip;
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_root_plus  = r_rp;
    assign o_root_minus = r_rm;
    assign o_real_part  = r_re;
    assign o_imag_part  = r_ip;

endmodule

/* rtl/core/quadratic_root_solver.sv */
// Path: o_valid strobes once an accepted word has passed the front, the
// SW = COEFF_WIDTH+FRAC_BITS+1 root cells, the setup, the
// NW = COEFF_WIDTH+FRAC_BITS+2 divider cells and the finish stage.
// Throughput: one word per cycle while busy is low; no cell ever stalls.
// Reset: synchronous, active low; clears all valid bits, busy is high for the
// reset cycle and the one after. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
// quadratic_root_solver: pipelined fixed-point quadratic equation solver
// Exact discriminant, a chain of square root cells and a chain of two-lane
// restoring divider cells, then sign, saturation and routing by kind.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int COEFF_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COEFF_WIDTH-1:0]  i_coeff_a,
    input  logic signed [COEFF_WIDTH-1:0]  i_coeff_b,
    input  logic signed [COEFF_WIDTH-1:0]  i_coeff_c,
    output logic                           o_valid,
    output logic [2:0]                     o_kind,
    output logic signed [ROOT_W-1:0]       o_root_plus,
    output logic signed [ROOT_W-1:0]       o_root_minus,
    output logic signed [ROOT_W-1:0]       o_real_part,
    output logic [IMAG_W-1:0]              o_imag_part
);

    localparam int W   = COEFF_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W + 2;
    localparam int SW  = W + F + 1;
    localparam int NW  = W + F + 2;
    localparam int DVW = W + 1;
    localparam int SBW = NW + DVW + 1;
    localparam int LAT = SW + NW + 5;

    logic r_busy;
    logic n_load;

    t_ctl                 f_ctl;
    logic [DW-1:0]        f_dmag;
    logic signed [NW-1:0] f_nb;
    logic [DVW-1:0]       f_den;
    logic                 f_den_neg;

    t_ctl             sq_ctl  [SW+1];
    logic [2*SW-1:0]  sq_rad  [SW+1];
    logic [SW+1:0]    sq_rem  [SW+1];
    logic [SW-1:0]    sq_root [SW+1];
    logic [SBW-1:0]   sq_side [SW+1];

    t_ctl                 dv_ctl [NW+1];
    logic [DVW-1:0]       dv_den [NW+1];
    logic [1:0][DVW-1:0]  dv_rem [NW+1];
    logic [1:0][NW-1:0]   dv_nq  [NW+1];
    logic [1:0]           dv_neg [NW+1];

    // hold busy through reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_busy <= 1'b1;
        else
            r_busy <= 1'b0;
    end

    assign busy   = r_busy;
    assign n_load = start && !r_busy;

    qrs_front #(.W(W), .F(F), .DW(DW), .NW(NW), .DVW(DVW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (n_load),
        .i_a       (i_coeff_a),
        .i_b       (i_coeff_b),
        .i_c       (i_coeff_c),
        .o_ctl     (f_ctl),
        .o_dmag    (f_dmag),
        .o_nb      (f_nb),
        .o_den     (f_den),
        .o_den_neg (f_den_neg)
    );

    // square root chain: radicand is |D| scaled by 2^(2F)
    assign sq_ctl[0]  = f_ctl;
    assign sq_rad[0]  = {f_dmag, {(2*F){1'b0}}};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {f_nb, f_den, f_den_neg};

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        qrs_sqrt_cell #(.SW(SW), .SBW(SBW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (sq_ctl[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_ctl   (sq_ctl[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    qrs_setup #(.SW(SW), .NW(NW), .DVW(DVW)) u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (sq_ctl[SW]),
        .i_root    (sq_root[SW]),
        .i_nb      (sq_side[SW][SBW-1 -: NW]),
        .i_den     (sq_side[SW][DVW:1]),
        .i_den_neg (sq_side[SW][0]),
        .o_ctl     (dv_ctl[0]),
        .o_num     (dv_nq[0]),
        .o_neg     (dv_neg[0]),
        .o_den     (dv_den[0])
    );

    // divider chain, one quotient bit per cell
    assign dv_rem[0] = '0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        qrs_div_cell #(.NW(NW), .DVW(DVW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (dv_ctl[k]),
            .i_den   (dv_den[k]),
            .i_rem   (dv_rem[k]),
            .i_nq    (dv_nq[k]),
            .i_neg   (dv_neg[k]),
            .o_ctl   (dv_ctl[k+1]),
            .o_den   (dv_den[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_nq    (dv_nq[k+1]),
            .o_neg   (dv_neg[k+1])
        );
    end

    qrs_finish #(.NW(NW)) u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (dv_ctl[NW]),
        .i_quo        (dv_nq[NW]),
        .i_neg        (dv_neg[NW]),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_root_plus  (o_root_plus),
        .o_root_minus (o_root_minus),
        .o_real_part  (o_real_part),
        .o_imag_part  (o_imag_part)
    );

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |-> ##LAT o_valid)
        else $error("result strobe missing after accepted word");

    // no equation leaves every result field at zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_NONE) |->
        (o_root_plus == '0 && o_root_minus == '0 && o_real_part == '0 &&
         o_imag_part == '0))
        else $error("fields not cleared for no equation");

    // imaginary part only for a complex pair
    a_imag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_COMPLEX) |-> (o_imag_part == '0))
        else $error("imaginary part set for a real solution");

    // no strobe straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("strobe after reset");

endmodule
